FILE: rtl/qrs_pkg.sv
package qrs_pkg;

  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // derived widths
  localparam int DMW  = 2 * COEF_WIDTH + 1;   // discriminant magnitude
  localparam int DSW  = DMW + 1;              // signed discriminant
  localparam int SW   = COEF_WIDTH + 1;       // square root
  localparam int RADW = 2 * SW;               // padded radicand
  localparam int REMW = SW + 2;               // root remainder
  localparam int NMW  = COEF_WIDTH + 2;       // numerator magnitude
  localparam int NW   = NMW + FRAC_BITS;      // scaled numerator / quotient
  localparam int DVW  = COEF_WIDTH + 1;       // divisor

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;
  localparam logic [1:0] CNT_INF  = 2'd3;

  typedef struct packed {
    logic signed [COEF_WIDTH-1:0] quad_coef;
    logic signed [COEF_WIDTH-1:0] lin_coef;
    logic signed [COEF_WIDTH-1:0] const_coef;
  } coef_in_t;

  typedef struct packed {
    logic [1:0]                   root_count;
    logic signed [COEF_WIDTH-1:0] first_root;
    logic signed [COEF_WIDTH-1:0] second_root;
    logic                         overflow;
  } root_out_t;

  typedef struct packed {
    logic [1:0]            count;
    logic                  nb_neg;
    logic [COEF_WIDTH-1:0] nb_mag;
    logic                  den_neg;
    logic [DVW-1:0]        den_mag;
  } side_t;

  typedef struct packed {
    logic [RADW-1:0] rad;
    logic [REMW-1:0] rem;
    logic [SW-1:0]   root;
    side_t           side;
  } sqrt_t;

  typedef struct packed {
    logic           neg;
    logic [NW-1:0]  num;
    logic [DVW-1:0] rem;
    logic [NW-1:0]  quo;
  } lane_t;

  typedef struct packed {
    logic [1:0]     count;
    logic [DVW-1:0] den_mag;
    lane_t          lane1;
    lane_t          lane2;
  } div_t;

endpackage

FILE: rtl/qrs_sqrt_cell.sv
module qrs_sqrt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  qrs_pkg::sqrt_t up_data,
  output logic          up_ready,
  output logic          dn_valid,
  output qrs_pkg::sqrt_t dn_data,
  input  logic          dn_ready
);

  logic           v_r;
  qrs_pkg::sqrt_t d_r;
  qrs_pkg::sqrt_t d_nxt;
  logic [qrs_pkg::REMW-1:0] rem2;
  logic [qrs_pkg::REMW-1:0] trial;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // one root bit: bring down two radicand bits, trial subtract
  always_comb begin
    rem2  = {up_data.rem[qrs_pkg::REMW-3:0], up_data.rad[qrs_pkg::RADW-1 -: 2]};
    trial = {up_data.root, 2'b01};
    d_nxt = up_data;
    d_nxt.rad = {up_data.rad[qrs_pkg::RADW-3:0], 2'b00};
    if (rem2 >= trial) begin
      d_nxt.rem  = rem2 - trial;
      d_nxt.root = {up_data.root[qrs_pkg::SW-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem2;
      d_nxt.root = {up_data.root[qrs_pkg::SW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

FILE: rtl/qrs_div_cell.sv
module qrs_div_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  input  qrs_pkg::div_t up_data,
  output logic          up_ready,
  output logic          dn_valid,
  output qrs_pkg::div_t dn_data,
  input  logic          dn_ready
);

  logic          v_r;
  qrs_pkg::div_t d_r;
  qrs_pkg::div_t d_nxt;

  function automatic qrs_pkg::lane_t step(qrs_pkg::lane_t l, logic [qrs_pkg::DVW-1:0] den);
    logic [qrs_pkg::DVW:0] rem2;
    logic [qrs_pkg::DVW:0] diff;
    logic                  ge;
    qrs_pkg::lane_t        r;
    rem2 = {l.rem, l.num[qrs_pkg::NW-1]};
    diff = rem2 - {1'b0, den};
    ge   = rem2 >= {1'b0, den};
    r     = l;
    r.num = {l.num[qrs_pkg::NW-2:0], 1'b0};
    r.rem = ge ? diff[qrs_pkg::DVW-1:0] : rem2[qrs_pkg::DVW-1:0];
    r.quo = {l.quo[qrs_pkg::NW-2:0], ge};
    return r;
  endfunction

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_comb begin
    d_nxt       = up_data;
    d_nxt.lane1 = step(up_data.lane1, up_data.den_mag);
    d_nxt.lane2 = step(up_data.lane2, up_data.den_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

FILE: rtl/quadratic_root_solver.sv
// pipeline: input register, square root row, divider row, output register; roots in Q16.16
// throughput: one transaction per cycle while out_stall is low; every cell of the
// square root and divider rows is a pipeline stage, bubbles collapse on a stall
// reset: rst_n synchronous active low, empties the pipeline and sets the
// zero tolerance to 0
module quadratic_root_solver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qrs_pkg::coef_in_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qrs_pkg::root_out_t  out_data,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);

  localparam int CW = qrs_pkg::COEF_WIDTH;

  // zero tolerance register
  logic [15:0] tol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= '0;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  // ---------------------------------------------------------------
  // stage 1: magnitudes and the two products
  // ---------------------------------------------------------------
  logic            p1_v_r;
  logic            p1_ready;
  logic            a_neg_r, b_neg_r, c_neg_r;
  logic [CW-1:0]   a_mag_r, b_mag_r, c_mag_r;
  logic [2*CW-1:0] bb_r, ac_r;
  logic [CW-1:0]   a_mag, b_mag, c_mag;

  assign a_mag = in_data.quad_coef[CW-1]  ? (~in_data.quad_coef  + 1'b1) : in_data.quad_coef;
  assign b_mag = in_data.lin_coef[CW-1]   ? (~in_data.lin_coef   + 1'b1) : in_data.lin_coef;
  assign c_mag = in_data.const_coef[CW-1] ? (~in_data.const_coef + 1'b1) : in_data.const_coef;

  assign in_stall = !p1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (p1_ready) begin
      p1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_ready && in_valid) begin
      a_neg_r <= in_data.quad_coef[CW-1];
      b_neg_r <= in_data.lin_coef[CW-1];
      c_neg_r <= in_data.const_coef[CW-1];
      a_mag_r <= a_mag;
      b_mag_r <= b_mag;
      c_mag_r <= c_mag;
      bb_r    <= b_mag * b_mag;
      ac_r    <= a_mag * c_mag;
    end
  end

  // ---------------------------------------------------------------
  // stage 2 (combinational into the first root cell): discriminant,
  // case decision and numerator/divisor selection
  // ---------------------------------------------------------------
  logic                      a_nz, b_nz, c_nz;
  logic                      pr_neg;
  logic [qrs_pkg::DSW-1:0]   d_sum;
  logic [qrs_pkg::DMW-1:0]   d_thresh;
  qrs_pkg::sqrt_t            sq_in;

  always_comb begin
    a_nz     = a_mag_r > CW'(tol_r);
    b_nz     = b_mag_r > CW'(tol_r);
    c_nz     = c_mag_r > CW'(tol_r);
    // sign of the -4ac term
    pr_neg   = (a_neg_r == c_neg_r) && (ac_r != '0);
    if (pr_neg) begin
      d_sum = qrs_pkg::DSW'(bb_r) - {ac_r, 2'b00};
    end else begin
      d_sum = qrs_pkg::DSW'(bb_r) + {ac_r, 2'b00};
    end
    d_thresh = qrs_pkg::DMW'(tol_r) << qrs_pkg::FRAC_BITS;

    sq_in      = '0;
    sq_in.rad  = qrs_pkg::RADW'(d_sum[qrs_pkg::DMW-1:0]);
    if (a_nz) begin
      // quadratic: numerator -b, divisor 2a
      sq_in.side.nb_neg  = !b_neg_r && (b_mag_r != '0);
      sq_in.side.nb_mag  = b_mag_r;
      sq_in.side.den_neg = a_neg_r;
      sq_in.side.den_mag = {a_mag_r, 1'b0};
      if (d_sum[qrs_pkg::DSW-1]) begin
        sq_in.side.count = qrs_pkg::CNT_NONE;
      end else if (d_sum[qrs_pkg::DMW-1:0] <= d_thresh) begin
        sq_in.side.count = qrs_pkg::CNT_ONE;
      end else begin
        sq_in.side.count = qrs_pkg::CNT_TWO;
      end
    end else if (b_nz) begin
      // linear: numerator -c, divisor b
      sq_in.side.nb_neg  = !c_neg_r && (c_mag_r != '0);
      sq_in.side.nb_mag  = c_mag_r;
      sq_in.side.den_neg = b_neg_r;
      sq_in.side.den_mag = qrs_pkg::DVW'(b_mag_r);
      sq_in.side.count   = qrs_pkg::CNT_ONE;
    end else begin
      sq_in.side.count   = c_nz ? qrs_pkg::CNT_NONE : qrs_pkg::CNT_INF;
    end
  end

  // ---------------------------------------------------------------
  // square root row: one result bit per cell
  // ---------------------------------------------------------------
  logic           sq_v   [qrs_pkg::SW];
  logic           sq_rdy [qrs_pkg::SW];
  qrs_pkg::sqrt_t sq_d   [qrs_pkg::SW];
  logic           dv_v   [qrs_pkg::NW];
  logic           dv_rdy [qrs_pkg::NW];
  qrs_pkg::div_t  dv_d   [qrs_pkg::NW];

  assign p1_ready = !p1_v_r || sq_rdy[0];

  genvar k;
  generate
    for (k = 0; k < qrs_pkg::SW; k++) begin : g_sq
      if (k == 0) begin : g_first
        qrs_sqrt_cell u_cell (
          .clk(clk), .rst_n(rst_n),
          .up_valid(p1_v_r), .up_data(sq_in), .up_ready(sq_rdy[k]),
          .dn_valid(sq_v[k]), .dn_data(sq_d[k]),
          .dn_ready(qrs_pkg::SW == 1 ? dv_rdy[0] : sq_rdy[(k+1) % qrs_pkg::SW])
        );
      end else begin : g_rest
        qrs_sqrt_cell u_cell (
          .clk(clk), .rst_n(rst_n),
          .up_valid(sq_v[k-1]), .up_data(sq_d[k-1]), .up_ready(sq_rdy[k]),
          .dn_valid(sq_v[k]), .dn_data(sq_d[k]),
          .dn_ready(k == qrs_pkg::SW-1 ? dv_rdy[0] : sq_rdy[(k+1) % qrs_pkg::SW])
        );
      end
    end
  endgenerate

  // ---------------------------------------------------------------
  // stage 3 (combinational into the first divider cell): numerators
  // -b + s and -b - s, or the single numerator
  // ---------------------------------------------------------------
  qrs_pkg::sqrt_t          sq_last;
  logic signed [qrs_pkg::NMW:0] nb_val, s_val, sum1, sum2;
  logic [qrs_pkg::NMW:0]   mag1, mag2;
  qrs_pkg::div_t           dv_in;

  assign sq_last = sq_d[qrs_pkg::SW-1];

  always_comb begin
    nb_val = sq_last.side.nb_neg ? -$signed((qrs_pkg::NMW+1)'(sq_last.side.nb_mag))
                                 :  $signed((qrs_pkg::NMW+1)'(sq_last.side.nb_mag));
    s_val  = $signed((qrs_pkg::NMW+1)'(sq_last.root));
    if (sq_last.side.count == qrs_pkg::CNT_TWO) begin
      sum1 = nb_val + s_val;
      sum2 = nb_val - s_val;
    end else begin
      sum1 = nb_val;
      sum2 = '0;
    end
    mag1 = sum1[qrs_pkg::NMW] ? -sum1 : sum1;
    mag2 = sum2[qrs_pkg::NMW] ? -sum2 : sum2;

    dv_in           = '0;
    dv_in.count     = sq_last.side.count;
    dv_in.den_mag   = sq_last.side.den_mag;
    dv_in.lane1.neg = sum1[qrs_pkg::NMW] ^ sq_last.side.den_neg;
    dv_in.lane1.num = {mag1[qrs_pkg::NMW-1:0], {qrs_pkg::FRAC_BITS{1'b0}}};
    dv_in.lane2.neg = sum2[qrs_pkg::NMW] ^ sq_last.side.den_neg;
    dv_in.lane2.num = {mag2[qrs_pkg::NMW-1:0], {qrs_pkg::FRAC_BITS{1'b0}}};
  end

  // ---------------------------------------------------------------
  // divider row: one quotient bit per cell, both roots side by side
  // ---------------------------------------------------------------
  logic out_ready;

  generate
    for (k = 0; k < qrs_pkg::NW; k++) begin : g_dv
      if (k == 0) begin : g_first
        qrs_div_cell u_cell (
          .clk(clk), .rst_n(rst_n),
          .up_valid(sq_v[qrs_pkg::SW-1]), .up_data(dv_in), .up_ready(dv_rdy[k]),
          .dn_valid(dv_v[k]), .dn_data(dv_d[k]),
          .dn_ready(dv_rdy[(k+1) % qrs_pkg::NW])
        );
      end else begin : g_rest
        qrs_div_cell u_cell (
          .clk(clk), .rst_n(rst_n),
          .up_valid(dv_v[k-1]), .up_data(dv_d[k-1]), .up_ready(dv_rdy[k]),
          .dn_valid(dv_v[k]), .dn_data(dv_d[k]),
          .dn_ready(k == qrs_pkg::NW-1 ? out_ready : dv_rdy[(k+1) % qrs_pkg::NW])
        );
      end
    end
  endgenerate

  // ---------------------------------------------------------------
  // stage 4: saturation, sign and result assembly into the output register
  // ---------------------------------------------------------------
  function automatic logic [CW:0] sat_root(qrs_pkg::lane_t l);
    logic [qrs_pkg::NW-1:0] limit;
    logic [qrs_pkg::NW-1:0] q;
    logic                   ovf;
    limit = l.neg ? (qrs_pkg::NW'(1) << (CW-1)) : ((qrs_pkg::NW'(1) << (CW-1)) - 1'b1);
    q     = l.quo;
    ovf   = q > limit;
    if (ovf) begin
      q = limit;
    end
    if (l.neg) begin
      q = -q;
    end
    return {ovf, q[CW-1:0]};
  endfunction

  qrs_pkg::div_t      dv_last;
  logic [CW:0]        r1, r2;
  qrs_pkg::root_out_t res;
  logic               out_v_r;
  qrs_pkg::root_out_t out_r;

  assign dv_last = dv_d[qrs_pkg::NW-1];

  always_comb begin
    r1  = sat_root(dv_last.lane1);
    r2  = sat_root(dv_last.lane2);
    res = '0;
    res.root_count = dv_last.count;
    case (dv_last.count)
      qrs_pkg::CNT_ONE: begin
        res.first_root = r1[CW-1:0];
        res.overflow   = r1[CW];
      end
      qrs_pkg::CNT_TWO: begin
        res.first_root  = r1[CW-1:0];
        res.second_root = r2[CW-1:0];
        res.overflow    = r1[CW] | r2[CW];
      end
      default: ;
    endcase
  end

  assign out_ready = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_ready) begin
      out_v_r <= dv_v[qrs_pkg::NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && dv_v[qrs_pkg::NW-1]) begin
      out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
